// ===== rtl/fbmt_pkg.sv =====
// Shared types, widths and codes for the flash block map translator.
`timescale 1ns / 1ps
`default_nettype none
package fbmt_pkg;

  localparam int MAP_DEPTH   = 4096;
  localparam int MAX_SECTORS = 8;
  localparam int MAP_AW      = $clog2(MAP_DEPTH);
  localparam int CNT_W       = $clog2(MAX_SECTORS + 1);

  localparam int SECTOR_SHIFT = 9;
  localparam int ADDR_W       = 32;
  localparam int INDEX_W      = 12;
  localparam int SECTOR_W     = 23;
  localparam int COUNT_W      = 4;
  localparam int SHIFT_W      = 5;
  localparam int NDB_W        = 13;
  localparam int PART_W       = 21;

  localparam int IN_DATA_W  = 72;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 21;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SHIFT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_DATA_BLOCKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PARTITION       = 2'd2;

  localparam logic [SHIFT_W-1:0] BLOCK_SHIFT_RST = 5'd14;
  localparam logic [NDB_W-1:0]   NUM_DATA_RST    = 13'd0;
  localparam logic [PART_W-1:0]  PARTITION_RST   = 21'd4096;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_XLATE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMD,
    ST_RUN
  } state_t;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_MISSING  = 2'd1,
    STS_RANGE    = 2'd2,
    STS_UNUSABLE = 2'd3
  } status_t;

endpackage
`default_nettype wire

// ===== rtl/flash_block_map_translator.sv =====
// Top level of the flash block map translator: map memory, sector sequencer, result register.
`timescale 1ns / 1ps
`default_nettype none
// A load, or a translate on an unusable map, is answered from the command state through the
//   result register; a translate reads the map, holds each sector in the pending slot and
//   moves it to the result register, one result per cycle while the result side does not
//   stall, set by the single read port of the map memory. A new item is taken only in idle,
//   so the block does not take a new item before it is done with the last one.
// Reset (rst_n low, synchronous) clears control state and the unusable mark and loads
//   the register defaults; the map memory is not cleared and needs no clearing pass.
module flash_block_map_translator (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input item channel
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // tdata, low bit up: map_index[11:0], map_value[43:12], start_sector[66:44],
  // sector_count[70:67], zero pad[71]
  input  wire logic [fbmt_pkg::IN_DATA_W-1:0] in_tdata,
  // tuser: command[0]
  input  wire logic [0:0]                     in_tuser,
  // result channel
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // tdata: flash byte address[31:0]
  output logic [fbmt_pkg::ADDR_W-1:0]         out_tdata,
  // tuser: status[1:0]
  output logic [1:0]                          out_tuser,
  output logic                                out_tlast,
  // configuration write channel
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [fbmt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fbmt_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fbmt_pkg::*;

  // configuration registers
  logic [SHIFT_W-1:0] block_shift_r;
  logic [NDB_W-1:0]   num_data_r;
  logic [PART_W-1:0]  partition_r;

  // control
  state_t             state_r, state_nxt;
  logic               unusable_r, unusable_nxt;
  logic [CNT_W-1:0]   rem_r, rem_nxt;
  logic               pend_r, pend_nxt;
  logic               pend_err_r, pend_err_nxt;
  logic               pend_last_r, pend_last_nxt;
  logic               out_vld_r, out_vld_nxt;

  // payload
  logic                cmd_r;
  logic [INDEX_W-1:0]  idx_r;
  logic [ADDR_W-1:0]   val_r;
  logic [SECTOR_W-1:0] start_r;
  logic [COUNT_W-1:0]  cnt_r;
  logic [SECTOR_W-1:0] sec_r, sec_nxt;
  logic [ADDR_W-1:0]   page_r, page_nxt;
  logic [ADDR_W-1:0]   out_addr_r, out_addr_nxt;
  status_t             out_sts_r, out_sts_nxt;
  logic                out_last_r, out_last_nxt;

  // map memory
  logic [ADDR_W-1:0]   map_mem [MAP_DEPTH];
  logic [ADDR_W-1:0]   rd_q;
  logic                rd_en, wr_en;
  logic [MAP_AW-1:0]   rd_addr, wr_addr;

  // combinational helpers
  logic                can_out, emit, slot_free, issue;
  logic [ADDR_W-1:0]   offset, logical, page_mask, idx_ext;
  logic                sec_err, idx_out;
  logic [CNT_W-1:0]    cnt_clamp;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_addr_r;
  assign out_tuser  = out_sts_r;
  assign out_tlast  = out_last_r;

  // The result register can take a new result when empty or being drained.
  assign can_out   = !out_vld_r || out_tready;
  assign emit      = (state_r == ST_RUN) && pend_r && can_out;
  assign slot_free = !pend_r || emit;
  assign issue     = (state_r == ST_RUN) && slot_free && (rem_r != '0);

  // Byte offset of the current sector wraps at 32 bits, so only the low 23 bits of
  // the sector number matter.
  assign offset    = {sec_r, {SECTOR_SHIFT{1'b0}}};
  assign logical   = offset >> block_shift_r;
  assign page_mask = (32'd1 << block_shift_r) - 32'd1;
  assign sec_err   = (logical >= {{(ADDR_W-NDB_W){1'b0}}, num_data_r}) ||
                     (logical >= 32'(MAP_DEPTH));
  assign rd_addr   = logical[MAP_AW-1:0];

  assign idx_ext   = {{(ADDR_W-INDEX_W){1'b0}}, idx_r};
  assign idx_out   = (idx_ext >= 32'(MAP_DEPTH));
  assign wr_addr   = idx_ext[MAP_AW-1:0];

  // Clamp the sector count into 1..MAX_SECTORS.
  always_comb begin
    if (cnt_r == '0) begin
      cnt_clamp = CNT_W'(1);
    end else if ({{(ADDR_W-COUNT_W){1'b0}}, cnt_r} > 32'(MAX_SECTORS)) begin
      cnt_clamp = CNT_W'(MAX_SECTORS);
    end else begin
      cnt_clamp = CNT_W'(cnt_r);
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_CMD;
        end
      end
      ST_CMD: begin
        if (cmd_r == CMD_XLATE && !unusable_r) begin
          state_nxt = ST_RUN;
        end else if (can_out) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RUN: begin
        // leave once nothing remains to issue and the last slot drains
        if (rem_r == '0 && slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    unusable_nxt  = unusable_r;
    rem_nxt       = rem_r;
    sec_nxt       = sec_r;
    page_nxt      = page_r;
    pend_nxt      = pend_r;
    pend_err_nxt  = pend_err_r;
    pend_last_nxt = pend_last_r;
    out_vld_nxt   = out_tready ? 1'b0 : out_vld_r;
    out_addr_nxt  = out_addr_r;
    out_sts_nxt   = out_sts_r;
    out_last_nxt  = out_last_r;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    case (state_r)
      ST_CMD: begin
        if (cmd_r == CMD_XLATE && !unusable_r) begin
          // start the sector walk
          rem_nxt  = cnt_clamp;
          sec_nxt  = start_r;
          pend_nxt = 1'b0;
        end else if (can_out) begin
          out_vld_nxt  = 1'b1;
          out_addr_nxt = '0;
          out_last_nxt = 1'b1;
          if (cmd_r == CMD_XLATE) begin
            out_sts_nxt = STS_UNUSABLE;
          end else if (idx_out) begin
            out_sts_nxt = STS_MISSING;
          end else if (val_r >= {{(ADDR_W-PART_W){1'b0}}, partition_r}) begin
            // reject the entry and mark the map unusable
            unusable_nxt = 1'b1;
            out_sts_nxt  = STS_RANGE;
          end else begin
            // a load at index 0 clears the mark; store the entry
            if (idx_r == '0) begin
              unusable_nxt = 1'b0;
            end
            wr_en       = 1'b1;
            out_sts_nxt = STS_OK;
          end
        end
      end
      ST_RUN: begin
        if (emit) begin
          out_vld_nxt  = 1'b1;
          out_last_nxt = pend_err_r || pend_last_r;
          if (pend_err_r) begin
            out_addr_nxt = '0;
            out_sts_nxt  = STS_MISSING;
          end else begin
            out_addr_nxt = (rd_q << block_shift_r) + page_r;
            out_sts_nxt  = STS_OK;
          end
          pend_nxt = 1'b0;
        end
        if (issue) begin
          pend_nxt = 1'b1;
          if (sec_err) begin
            // stop the item at the first missing block
            pend_err_nxt = 1'b1;
            rem_nxt      = '0;
          end else begin
            rd_en         = 1'b1;
            pend_err_nxt  = 1'b0;
            pend_last_nxt = (rem_r == CNT_W'(1));
            page_nxt      = offset & page_mask;
            rem_nxt       = rem_r - CNT_W'(1);
            sec_nxt       = sec_r + SECTOR_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Loads and translations never overlap, so a read never meets a write to the same entry.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[wr_addr] <= val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= map_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_shift_r <= BLOCK_SHIFT_RST;
      num_data_r    <= NUM_DATA_RST;
      partition_r   <= PARTITION_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BLOCK_SHIFT:     block_shift_r <= cfg_data[SHIFT_W-1:0];
        CFG_NUM_DATA_BLOCKS: num_data_r    <= cfg_data[NDB_W-1:0];
        CFG_PARTITION:       partition_r   <= cfg_data[PART_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      unusable_r <= 1'b0;
      rem_r      <= '0;
      pend_r     <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      unusable_r <= unusable_nxt;
      rem_r      <= rem_nxt;
      pend_r     <= pend_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r   <= in_tuser[0];
      idx_r   <= in_tdata[11:0];
      val_r   <= in_tdata[43:12];
      start_r <= in_tdata[66:44];
      cnt_r   <= in_tdata[70:67];
    end
    sec_r       <= sec_nxt;
    page_r      <= page_nxt;
    pend_err_r  <= pend_err_nxt;
    pend_last_r <= pend_last_nxt;
    out_addr_r  <= out_addr_nxt;
    out_sts_r   <= out_sts_nxt;
    out_last_r  <= out_last_nxt;
  end

  // An error result always closes its item.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_sts_r != STS_OK |-> out_last_r)
    else $error("error result without last");

  // No pending sector and nothing left to issue while waiting for an item.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !pend_r && rem_r == '0)
    else $error("sector work left over in idle");

  // A map read always fills the pending slot with a good sector.
  assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |=> pend_r && !pend_err_r)
    else $error("map read without pending sector");

  // The map is never written during a sector walk.
  assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> state_r == ST_CMD && !pend_r)
    else $error("map write during translation");

endmodule
`default_nettype wire
